FILE: hw/rtl/desf_pkg.sv
// Shared types and constants for the dual encoder speed filter.
// Holds the request and result payload structs, the register map and the filter limits.
// No dependencies.
package desf_pkg;

    typedef struct packed {
        logic req_type;
        logic channel;
        logic b_level;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] pos_left;
        logic signed [31:0] pos_right;
        logic [1:0]         dir_left;
        logic [1:0]         dir_right;
        logic signed [23:0] speed_left;
        logic signed [23:0] speed_right;
    } t_out_res;

    typedef struct packed {
        logic [15:0] input_gain;
        logic [15:0] feedback_gain;
        logic [7:0]  speed_scale;
        logic        invert_left;
        logic        invert_right;
    } t_cfg;

    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_INPUT_GAIN    = 3'd0;
    localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd1;
    localparam logic [2:0] REG_SPEED_SCALE   = 3'd2;
    localparam logic [2:0] REG_INVERT_LEFT   = 3'd3;
    localparam logic [2:0] REG_INVERT_RIGHT  = 3'd4;

    localparam logic [15:0] RST_INPUT_GAIN    = 16'd6237;
    localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd59299;
    localparam logic [7:0]  RST_SPEED_SCALE   = 8'd12;
    localparam logic        RST_INVERT_LEFT   = 1'b0;
    localparam logic        RST_INVERT_RIGHT  = 1'b1;

    localparam int COEF_BITS = 16;
    localparam int MUL_A_W   = 17;
    localparam int MUL_B_W   = 41;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam logic signed [39:0] FV_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] FV_MIN = {1'b1, {39{1'b0}}};

    localparam logic signed [15:0] DELTA_MAX = 16'sh7FFF;
    localparam logic signed [15:0] DELTA_MIN = 16'sh8000;

    localparam logic signed [39:0] SPEED_MAX = 40'sh00007FFFFF;
    localparam logic signed [39:0] SPEED_MIN = -40'sh0000800000;

    function automatic logic signed [23:0] sat_speed(input logic signed [39:0] x);
        logic signed [23:0] res;
        if (x > SPEED_MAX) begin
            res = SPEED_MAX[23:0];
        end else if (x < SPEED_MIN) begin
            res = SPEED_MIN[23:0];
        end else begin
            res = x[23:0];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/desf_cfg.sv
// Configuration register file with an APB-style write and read port.
// Depends on desf_pkg for the register map, reset values and the t_cfg struct.
module desf_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [desf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output desf_pkg::t_cfg               o_cfg
);

    desf_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[desf_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_gain    <= desf_pkg::RST_INPUT_GAIN;
            r_cfg.feedback_gain <= desf_pkg::RST_FEEDBACK_GAIN;
            r_cfg.speed_scale   <= desf_pkg::RST_SPEED_SCALE;
            r_cfg.invert_left   <= desf_pkg::RST_INVERT_LEFT;
            r_cfg.invert_right  <= desf_pkg::RST_INVERT_RIGHT;
        end else if (wr_en) begin
            case (reg_idx)
                desf_pkg::REG_INPUT_GAIN:    r_cfg.input_gain    <= pwdata[15:0];
                desf_pkg::REG_FEEDBACK_GAIN: r_cfg.feedback_gain <= pwdata[15:0];
                desf_pkg::REG_SPEED_SCALE:   r_cfg.speed_scale   <= pwdata[7:0];
                desf_pkg::REG_INVERT_LEFT:   r_cfg.invert_left   <= pwdata[0];
                desf_pkg::REG_INVERT_RIGHT:  r_cfg.invert_right  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            desf_pkg::REG_INPUT_GAIN:    prdata = {16'd0, r_cfg.input_gain};
            desf_pkg::REG_FEEDBACK_GAIN: prdata = {16'd0, r_cfg.feedback_gain};
            desf_pkg::REG_SPEED_SCALE:   prdata = {24'd0, r_cfg.speed_scale};
            desf_pkg::REG_INVERT_LEFT:   prdata = {31'd0, r_cfg.invert_left};
            desf_pkg::REG_INVERT_RIGHT:  prdata = {31'd0, r_cfg.invert_right};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

FILE: hw/rtl/desf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on desf_pkg for the operand and product widths.
module desf_mul (
    input  logic                                  i_clk,
    input  logic signed [desf_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [desf_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [desf_pkg::MUL_P_W-1:0]   o_p
);

    logic signed [desf_pkg::MUL_P_W-1:0] r_p;

    assign o_p = r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

endmodule

FILE: hw/rtl/desf_core.sv
// Sequencer and datapath: encoder counters, tick deltas and the per-channel filter state.
// Depends on desf_pkg and drives the shared multiplier desf_mul.
module desf_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  desf_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  desf_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output desf_pkg::t_out_res o_out_data
);

    localparam int SHL = (FRAC_BITS >= desf_pkg::COEF_BITS) ? FRAC_BITS - desf_pkg::COEF_BITS : 0;
    localparam int SHR = (FRAC_BITS <  desf_pkg::COEF_BITS) ? desf_pkg::COEF_BITS - FRAC_BITS : 0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_RAW,
        S_IN,
        S_FB,
        S_SUM,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_ch;
    logic [31:0]           r_pos  [2];
    logic [31:0]           r_last [2];
    logic [1:0]            r_dir  [2];
    logic signed [39:0]    r_fv   [2];
    logic signed [15:0]    r_delta;
    logic signed [48:0]    r_in_term;
    logic                  r_out_valid;
    desf_pkg::t_out_res    r_out;

    logic signed [desf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [desf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [desf_pkg::MUL_P_W-1:0] mul_p;

    logic signed [31:0]    diff;
    logic signed [15:0]    delta_sat;
    logic signed [48:0]    in_ext;
    logic signed [48:0]    in_sh;
    logic signed [39:0]    fb_term;
    logic signed [49:0]    sum;
    logic signed [39:0]    sum_sat;
    logic                  pulse_inv;
    desf_pkg::t_out_res    result;

    desf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        diff = $signed(r_pos[r_ch] - r_last[r_ch]);
        if (diff > $signed({{16{1'b0}}, desf_pkg::DELTA_MAX})) begin
            delta_sat = desf_pkg::DELTA_MAX;
        end else if (diff < $signed({{16{1'b1}}, desf_pkg::DELTA_MIN})) begin
            delta_sat = desf_pkg::DELTA_MIN;
        end else begin
            delta_sat = diff[15:0];
        end
    end

    always_comb begin
        case (r_state)
            S_RAW: begin
                mul_a = {1'b0, 8'd0, i_cfg.speed_scale};
                mul_b = {{25{r_delta[15]}}, r_delta};
            end
            S_IN: begin
                mul_a = {1'b0, i_cfg.input_gain};
                mul_b = {{17{mul_p[23]}}, mul_p[23:0]};
            end
            S_FB: begin
                mul_a = {1'b0, i_cfg.feedback_gain};
                mul_b = {r_fv[r_ch][39], r_fv[r_ch]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign in_ext = {{9{mul_p[39]}}, mul_p[39:0]};
    assign in_sh  = (FRAC_BITS >= desf_pkg::COEF_BITS) ? (in_ext <<< SHL) : (in_ext >>> SHR);

    assign fb_term = mul_p[55:16];
    assign sum     = {r_in_term[48], r_in_term} + {{10{fb_term[39]}}, fb_term};

    always_comb begin
        if (sum > $signed({{10{1'b0}}, desf_pkg::FV_MAX})) begin
            sum_sat = desf_pkg::FV_MAX;
        end else if (sum < $signed({{10{1'b1}}, desf_pkg::FV_MIN})) begin
            sum_sat = desf_pkg::FV_MIN;
        end else begin
            sum_sat = sum[39:0];
        end
    end

    assign pulse_inv = i_in_data.channel ? i_cfg.invert_right : i_cfg.invert_left;

    always_comb begin
        result.pos_left    = $signed(r_pos[0]);
        result.pos_right   = $signed(r_pos[1]);
        result.dir_left    = r_dir[0];
        result.dir_right   = r_dir[1];
        result.speed_left  = desf_pkg::sat_speed(r_fv[0] >>> FRAC_BITS);
        result.speed_right = desf_pkg::sat_speed(r_fv[1] >>> FRAC_BITS);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_pos[c]  <= '0;
                r_last[c] <= '0;
                r_dir[c]  <= desf_pkg::DIR_NONE;
                r_fv[c]   <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.req_type == desf_pkg::REQ_PULSE) begin
                            if (i_in_data.b_level ^ pulse_inv) begin
                                r_pos[i_in_data.channel] <= r_pos[i_in_data.channel] + 32'd1;
                                r_dir[i_in_data.channel] <= desf_pkg::DIR_FWD;
                            end else begin
                                r_pos[i_in_data.channel] <= r_pos[i_in_data.channel] - 32'd1;
                                r_dir[i_in_data.channel] <= desf_pkg::DIR_REV;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_ch    <= 1'b0;
                            r_state <= S_DELTA;
                        end
                    end
                end
                S_DELTA: begin
                    r_delta      <= delta_sat;
                    r_last[r_ch] <= r_pos[r_ch];
                    r_state      <= S_RAW;
                end
                S_RAW: begin
                    r_state <= S_IN;
                end
                S_IN: begin
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_in_term <= in_sh;
                    r_state   <= S_SUM;
                end
                S_SUM: begin
                    r_fv[r_ch] <= sum_sat;
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_DELTA;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/dual_encoder_speed_filter.sv
// Dual encoder counter with filtered speed: a pulse request goes from idle through the done state to its result,
// a tick request through five steps per channel on the one shared multiplier and then the done state.
// One request is in work at a time; the next is taken once the result is in the output register.
// Synchronous active-low reset clears counts, directions, filter state and loads register defaults.
// Depends on desf_pkg, desf_cfg, desf_mul and desf_core.
module dual_encoder_speed_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  desf_pkg::t_in_req            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output desf_pkg::t_out_res           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [desf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    desf_pkg::t_cfg cfg;

    assign pready = 1'b1;

    desf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    desf_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_one_request_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_pulse_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.req_type == desf_pkg::REQ_PULSE
         && !o_out_valid) |-> ##2 o_out_valid)
        else $error("pulse result not delivered on time");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.dir_left != 2'd3 && o_out_data.dir_right != 2'd3))
        else $error("direction outside its codes");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for dual_encoder_speed_filter: encoder pulses, sample ticks and
// register writes, with every result compared against a built-in prediction of counts and speeds.
// Depends on desf_pkg and the dual_encoder_speed_filter RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int  FRAC        = 16;
    localparam int  LIMIT       = 4_000_000;
    localparam int  HOLD_CYCLES = 400;
    localparam int  BIG_RUN     = 100;
    localparam logic CH_LEFT    = 1'b0;
    localparam logic CH_RIGHT   = 1'b1;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         in_valid;
    logic                         in_stall;
    desf_pkg::t_in_req            in_data;
    logic                         out_valid;
    logic                         out_stall;
    desf_pkg::t_out_res           out_data;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [desf_pkg::ADDR_W-1:0]  paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    desf_pkg::t_in_req   encoder_events[$];
    desf_pkg::t_out_res  expected_reports[$];

    desf_pkg::t_cfg filter_cfg;
    logic [31:0] enc_pos [2];
    logic [31:0] tick_pos [2];
    logic [1:0]  enc_dir [2];
    longint      filt [2];

    int  cycle_count;
    int  fail_count;
    int  pulse_count;
    int  tick_count;
    int  result_count;
    int  write_count;
    int  delta_clamps;
    int  filter_clamps;
    int  hold_requests;
    int  hold_seen;
    int  hold_left;
    bit  quiet;
    bit  req_taken;
    logic heading [2];

    dual_encoder_speed_filter #(.FRAC_BITS(FRAC)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic desf_pkg::t_in_req make_event(input logic kind, input logic ch,
                                                     input logic b);
        desf_pkg::t_in_req r;
        r.req_type = kind;
        r.channel  = ch;
        r.b_level  = b;
        return r;
    endfunction

    function automatic desf_pkg::t_out_res predict_encoder(input desf_pkg::t_in_req r);
        desf_pkg::t_out_res res;
        logic [31:0] moved;
        logic        invert;
        logic [23:0] speed_est [2];
        longint      delta, gain_in, gain_fb, scale, in_term, fb_term, sum, spd;
        longint      fv_hi, fv_lo, spd_hi, spd_lo, d_hi, d_lo;
        fv_hi  = desf_pkg::FV_MAX;
        fv_lo  = desf_pkg::FV_MIN;
        spd_hi = desf_pkg::SPEED_MAX;
        spd_lo = desf_pkg::SPEED_MIN;
        d_hi   = desf_pkg::DELTA_MAX;
        d_lo   = desf_pkg::DELTA_MIN;
        if (r.req_type == desf_pkg::REQ_PULSE) begin
            pulse_count++;
            invert = (r.channel == CH_RIGHT) ? filter_cfg.invert_right : filter_cfg.invert_left;
            if (r.b_level ^ invert) begin
                enc_pos[r.channel] = enc_pos[r.channel] + 32'd1;
                enc_dir[r.channel] = desf_pkg::DIR_FWD;
            end else begin
                enc_pos[r.channel] = enc_pos[r.channel] - 32'd1;
                enc_dir[r.channel] = desf_pkg::DIR_REV;
            end
        end else begin
            tick_count++;
            for (int c = 0; c < 2; c++) begin
                moved = enc_pos[c] - tick_pos[c];
                delta = longint'($signed(moved));
                if (delta > d_hi || delta < d_lo) begin
                    delta_clamps++;
                    delta = (delta > d_hi) ? d_hi : d_lo;
                end
                scale   = filter_cfg.speed_scale;
                gain_in = filter_cfg.input_gain;
                gain_fb = filter_cfg.feedback_gain;
                in_term = gain_in * delta * scale;
                if (FRAC >= desf_pkg::COEF_BITS) begin
                    in_term = in_term <<< (FRAC - desf_pkg::COEF_BITS);
                end else begin
                    in_term = in_term >>> (desf_pkg::COEF_BITS - FRAC);
                end
                fb_term = (gain_fb * filt[c]) >>> desf_pkg::COEF_BITS;
                sum = in_term + fb_term;
                if (sum > fv_hi || sum < fv_lo) begin
                    filter_clamps++;
                    sum = (sum > fv_hi) ? fv_hi : fv_lo;
                end
                filt[c]     = sum;
                tick_pos[c] = enc_pos[c];
            end
        end
        for (int c = 0; c < 2; c++) begin
            spd = filt[c] >>> FRAC;
            if (spd > spd_hi) begin
                spd = spd_hi;
            end else if (spd < spd_lo) begin
                spd = spd_lo;
            end
            speed_est[c] = spd[23:0];
        end
        res.pos_left    = enc_pos[0];
        res.pos_right   = enc_pos[1];
        res.dir_left    = enc_dir[0];
        res.dir_right   = enc_dir[1];
        res.speed_left  = speed_est[0];
        res.speed_right = speed_est[1];
        return res;
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Acceptance and result checking, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                result_count++;
                if (expected_reports.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    desf_pkg::t_out_res want;
                    want = expected_reports.pop_front();
                    check_field("pos_left", want.pos_left, out_data.pos_left);
                    check_field("pos_right", want.pos_right, out_data.pos_right);
                    check_field("dir_left", want.dir_left, out_data.dir_left);
                    check_field("dir_right", want.dir_right, out_data.dir_right);
                    check_field("speed_left", want.speed_left, out_data.speed_left);
                    check_field("speed_right", want.speed_right, out_data.speed_right);
                end
            end
            req_taken = in_valid && !in_stall;
            if (req_taken) begin
                expected_reports.push_back(predict_encoder(in_data));
            end
        end else begin
            req_taken = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || req_taken) begin
            if (encoder_events.size() > 0 && (quiet || $urandom_range(99) >= 15)) begin
                in_valid <= 1'b1;
                in_data  <= encoder_events.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic settle();
        do begin
            @(posedge i_clk);
        end while (encoder_events.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] want;
        bit          known;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (pready !== 1'b1) begin
            $error("pready low during a register write");
            fail_count++;
        end
        write_count++;
        known = 1'b1;
        case (idx)
            desf_pkg::REG_INPUT_GAIN: begin
                filter_cfg.input_gain = value[15:0];
                want = {16'd0, filter_cfg.input_gain};
            end
            desf_pkg::REG_FEEDBACK_GAIN: begin
                filter_cfg.feedback_gain = value[15:0];
                want = {16'd0, filter_cfg.feedback_gain};
            end
            desf_pkg::REG_SPEED_SCALE: begin
                filter_cfg.speed_scale = value[7:0];
                want = {24'd0, filter_cfg.speed_scale};
            end
            desf_pkg::REG_INVERT_LEFT: begin
                filter_cfg.invert_left = value[0];
                want = {31'd0, filter_cfg.invert_left};
            end
            desf_pkg::REG_INVERT_RIGHT: begin
                filter_cfg.invert_right = value[0];
                want = {31'd0, filter_cfg.invert_right};
            end
            default: begin
                known = 1'b0;
                want  = '0;
            end
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (known && prdata !== want) begin
            $error("register %0d readback mismatch: expected %0d, got %0d", idx, want, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_filter(input logic [15:0] g_in, input logic [15:0] g_fb,
                              input logic [7:0] scale, input logic inv_l, input logic inv_r);
        settle();
        reg_write(desf_pkg::REG_INPUT_GAIN, {16'd0, g_in});
        reg_write(desf_pkg::REG_FEEDBACK_GAIN, {16'd0, g_fb});
        reg_write(desf_pkg::REG_SPEED_SCALE, {24'd0, scale});
        reg_write(desf_pkg::REG_INVERT_LEFT, {31'd0, inv_l});
        reg_write(desf_pkg::REG_INVERT_RIGHT, {31'd0, inv_r});
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_scale();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Mostly steady motion per wheel, with occasional reversals, jitter and ticks.
    task automatic queue_motion(input int count);
        int   roll;
        logic ch;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            ch   = 1'($urandom_range(1));
            if (roll < 12) begin
                encoder_events.push_back(make_event(desf_pkg::REQ_TICK, ch,
                                                    1'($urandom_range(1))));
            end else begin
                if ($urandom_range(99) < 3) begin
                    heading[ch] = ~heading[ch];
                end
                encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, ch,
                                                    (roll < 90) ? heading[ch] : ~heading[ch]));
            end
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        out_stall = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        heading[0] = 1'b1;
        heading[1] = 1'b0;
        filter_cfg = '{desf_pkg::RST_INPUT_GAIN, desf_pkg::RST_FEEDBACK_GAIN,
                       desf_pkg::RST_SPEED_SCALE, desf_pkg::RST_INVERT_LEFT,
                       desf_pkg::RST_INVERT_RIGHT};
        for (int c = 0; c < 2; c++) begin
            enc_pos[c]  = '0;
            tick_pos[c] = '0;
            enc_dir[c]  = desf_pkg::DIR_NONE;
            filt[c]     = 0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: count sense per wheel, direction updates, ticks with stray fields.
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_LEFT, 1'b0));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b0));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b0));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_RIGHT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_LEFT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_RIGHT, 1'b0));

        set_filter(16'd0, 16'd0, 8'd0, 1'b1, 1'b0);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b0));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b0));
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_RIGHT, 1'b1));

        set_filter(16'hFFFF, 16'd0, 8'd1, 1'b0, 1'b1);
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_LEFT, 1'b0));

        set_filter(16'd0, 16'hFFFF, 8'd255, 1'b0, 1'b1);
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_LEFT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_RIGHT, 1'b0));

        // Clear both filters, then run each wheel one way for a long stretch while the
        // output is held off, and follow with a shorter run and two ticks at full gains.
        set_filter(16'd0, 16'd0, 8'd255, 1'b0, 1'b1);
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_LEFT, 1'b0));
        set_filter(16'hFFFF, 16'hFFFF, 8'd255, 1'b0, 1'b1);
        for (int i = 0; i < BIG_RUN; i++) begin
            encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b1));
            encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b1));
        end
        hold_requests++;
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_LEFT, 1'b0));
        for (int i = 0; i < 60; i++) begin
            encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_LEFT, 1'b1));
            encoder_events.push_back(make_event(desf_pkg::REQ_PULSE, CH_RIGHT, 1'b1));
        end
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_RIGHT, 1'b1));
        encoder_events.push_back(make_event(desf_pkg::REQ_TICK, CH_LEFT, 1'b1));

        for (int phase = 0; phase < 6; phase++) begin
            set_filter(pick_gain(), pick_gain(), pick_scale(),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
            quiet = (phase == 2);
            queue_motion(200);
            settle();
        end
        quiet = 1'b0;

        settle();
        repeat (30) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d results never arrived", expected_reports.size());
            fail_count++;
        end
        $display("Covered %0d pulses and %0d ticks over %0d register writes; %0d results checked.",
                 pulse_count, tick_count, write_count, result_count);
        $display("Count change clamped %0d times, filter state clamped %0d times.",
                 delta_clamps, filter_clamps);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/desf_pkg.sv
hw/rtl/desf_cfg.sv
hw/rtl/desf_mul.sv
hw/rtl/desf_core.sv
hw/rtl/dual_encoder_speed_filter.sv
tb/testbench.sv
